// ----- rtl/flt_pkg.sv -----
package flt_pkg;

    // Microcode step addresses
    typedef logic [3:0] t_pc;

    localparam t_pc PC_IDLE   = 4'd0;
    localparam t_pc PC_CHK_D  = 4'd1;
    localparam t_pc PC_CHK_N  = 4'd2;
    localparam t_pc PC_PAIR   = 4'd3;
    localparam t_pc PC_UEVEN  = 4'd4;
    localparam t_pc PC_VEVEN  = 4'd5;
    localparam t_pc PC_SUB    = 4'd6;
    localparam t_pc PC_GCD    = 4'd7;
    localparam t_pc PC_DIVN   = 4'd8;
    localparam t_pc PC_NEXTD  = 4'd9;
    localparam t_pc PC_DIVD   = 4'd10;
    localparam t_pc PC_EMIT   = 4'd11;
    localparam t_pc PC_ERR    = 4'd12;
    localparam t_pc PC_ZERO   = 4'd13;

    typedef enum logic [3:0] {
        OP_NONE       = 4'd0,
        OP_LOAD       = 4'd1,
        OP_HALVE_BOTH = 4'd2,
        OP_HALVE_U    = 4'd3,
        OP_HALVE_V    = 4'd4,
        OP_SUB        = 4'd5,
        OP_START_N    = 4'd6,
        OP_DIV_STEP   = 4'd7,
        OP_START_D    = 4'd8,
        OP_EMIT       = 4'd9,
        OP_EMIT_ERR   = 4'd10,
        OP_EMIT_ZERO  = 4'd11
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER         = 4'd0,
        C_NO_INPUT      = 4'd1,
        C_DEN_ZERO      = 4'd2,
        C_NUM_ZERO      = 4'd3,
        C_NOT_BOTH_EVEN = 4'd4,
        C_U_ODD         = 4'd5,
        C_V_ODD         = 4'd6,
        C_U_EQ_V        = 4'd7,
        C_CNT_DONE      = 4'd8,
        C_OUT_BUSY      = 4'd9
    } t_cond;

    // When the condition holds the step jumps to jt and does nothing;
    // otherwise it performs op and goes to jf.
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   jt;
        t_pc   jf;
    } t_uword;

    typedef struct packed {
        logic den_zero;
        logic num_zero;
        logic u_even;
        logic v_even;
        logic u_eq_v;
        logic cnt_done;
    } t_dp_flags;

    function automatic t_uword ucode_word(input t_pc pc);
        t_uword w;
        w = '{op: OP_NONE, cond: C_NEVER, jt: PC_IDLE, jf: PC_IDLE};
        unique case (pc)
            PC_IDLE:  w = '{op: OP_LOAD,       cond: C_NO_INPUT,      jt: PC_IDLE,  jf: PC_CHK_D};
            PC_CHK_D: w = '{op: OP_NONE,       cond: C_DEN_ZERO,      jt: PC_ERR,   jf: PC_CHK_N};
            PC_CHK_N: w = '{op: OP_NONE,       cond: C_NUM_ZERO,      jt: PC_ZERO,  jf: PC_PAIR};
            PC_PAIR:  w = '{op: OP_HALVE_BOTH, cond: C_NOT_BOTH_EVEN, jt: PC_UEVEN, jf: PC_PAIR};
            PC_UEVEN: w = '{op: OP_HALVE_U,    cond: C_U_ODD,         jt: PC_VEVEN, jf: PC_UEVEN};
            PC_VEVEN: w = '{op: OP_HALVE_V,    cond: C_V_ODD,         jt: PC_SUB,   jf: PC_VEVEN};
            PC_SUB:   w = '{op: OP_SUB,        cond: C_U_EQ_V,        jt: PC_GCD,   jf: PC_UEVEN};
            PC_GCD:   w = '{op: OP_START_N,    cond: C_NEVER,         jt: PC_IDLE,  jf: PC_DIVN};
            PC_DIVN:  w = '{op: OP_DIV_STEP,   cond: C_CNT_DONE,      jt: PC_NEXTD, jf: PC_DIVN};
            PC_NEXTD: w = '{op: OP_START_D,    cond: C_NEVER,         jt: PC_IDLE,  jf: PC_DIVD};
            PC_DIVD:  w = '{op: OP_DIV_STEP,   cond: C_CNT_DONE,      jt: PC_EMIT,  jf: PC_DIVD};
            PC_EMIT:  w = '{op: OP_EMIT,       cond: C_OUT_BUSY,      jt: PC_EMIT,  jf: PC_IDLE};
            PC_ERR:   w = '{op: OP_EMIT_ERR,   cond: C_OUT_BUSY,      jt: PC_ERR,   jf: PC_IDLE};
            PC_ZERO:  w = '{op: OP_EMIT_ZERO,  cond: C_OUT_BUSY,      jt: PC_ZERO,  jf: PC_IDLE};
            default:  w = '{op: OP_NONE,       cond: C_NEVER,         jt: PC_IDLE,  jf: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/flt_useq.sv -----
module flt_useq import flt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_busy,
    input  t_dp_flags i_flags,
    output logic      o_in_ready,
    output t_op       o_op
);

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w_word;
    logic   w_cond;

    assign w_word = ucode_word(r_pc);

    always_comb begin
        unique case (w_word.cond)
            C_NEVER:         w_cond = 1'b0;
            C_NO_INPUT:      w_cond = !i_in_valid;
            C_DEN_ZERO:      w_cond = i_flags.den_zero;
            C_NUM_ZERO:      w_cond = i_flags.num_zero;
            C_NOT_BOTH_EVEN: w_cond = !(i_flags.u_even && i_flags.v_even);
            C_U_ODD:         w_cond = !i_flags.u_even;
            C_V_ODD:         w_cond = !i_flags.v_even;
            C_U_EQ_V:        w_cond = i_flags.u_eq_v;
            C_CNT_DONE:      w_cond = i_flags.cnt_done;
            C_OUT_BUSY:      w_cond = i_out_busy;
            default:         w_cond = 1'b0;
        endcase
    end

    assign n_pc       = w_cond ? w_word.jt : w_word.jf;
    assign o_op       = w_cond ? OP_NONE : w_word.op;
    assign o_in_ready = (r_pc == PC_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ----- rtl/flt_datapath.sv -----
module flt_datapath import flt_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  t_op              i_op,
    input  logic [WIDTH-1:0] i_num,
    input  logic [WIDTH-1:0] i_den,
    output t_dp_flags        o_flags,
    output logic             o_emit,
    output logic [WIDTH-1:0] o_num,
    output logic [WIDTH-1:0] o_den,
    output logic             o_status
);

    localparam int KW = $clog2(WIDTH);
    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_nmag, r_dmag;
    logic             r_nneg, r_dneg;
    logic [WIDTH-1:0] r_u, r_v;
    logic [KW-1:0]    r_k;
    logic [WIDTH-1:0] r_q, r_rem;
    logic [CW-1:0]    r_cnt;

    logic [WIDTH-1:0] w_trial;
    logic             w_fits;
    logic [WIDTH-1:0] w_quot_signed;

    // Remainder stays below the divisor, which is at most half the range,
    // so its top bit is always clear and the shifted trial fits.
    assign w_trial       = {r_rem[WIDTH-2:0], r_q[WIDTH-1]};
    assign w_fits        = (w_trial >= r_u);
    assign w_quot_signed = r_nneg ? (~r_q + 1'b1) : r_q;

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_nneg <= i_num[WIDTH-1];
                r_dneg <= i_den[WIDTH-1];
                r_nmag <= i_num[WIDTH-1] ? (~i_num + 1'b1) : i_num;
                r_dmag <= i_den[WIDTH-1] ? (~i_den + 1'b1) : i_den;
                r_u    <= i_num[WIDTH-1] ? (~i_num + 1'b1) : i_num;
                r_v    <= i_den[WIDTH-1] ? (~i_den + 1'b1) : i_den;
                r_k    <= '0;
            end
            OP_HALVE_BOTH: begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + 1'b1;
            end
            OP_HALVE_U: r_u <= r_u >> 1;
            OP_HALVE_V: r_v <= r_v >> 1;
            OP_SUB: begin
                if (r_u > r_v) begin
                    r_u <= r_u - r_v;
                end else begin
                    r_v <= r_v - r_u;
                end
            end
            OP_START_N: begin
                // Restore the common power of two to form the gcd.
                r_u   <= r_u << r_k;
                r_q   <= r_nmag;
                r_rem <= '0;
                r_cnt <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= w_fits ? (w_trial - r_u) : w_trial;
                r_q   <= {r_q[WIDTH-2:0], w_fits};
                r_cnt <= r_cnt + 1'b1;
            end
            OP_START_D: begin
                o_num  <= w_quot_signed;
                r_nneg <= r_dneg;
                r_q    <= r_dmag;
                r_rem  <= '0;
                r_cnt  <= '0;
            end
            OP_EMIT: begin
                o_den    <= w_quot_signed;
                o_status <= 1'b0;
            end
            OP_EMIT_ERR: begin
                o_num    <= r_nneg ? (~r_nmag + 1'b1) : r_nmag;
                o_den    <= '0;
                o_status <= 1'b1;
            end
            OP_EMIT_ZERO: begin
                o_num    <= '0;
                o_den    <= {{(WIDTH-1){1'b0}}, 1'b1};
                o_status <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_emit = (i_op == OP_EMIT) || (i_op == OP_EMIT_ERR) || (i_op == OP_EMIT_ZERO);

    assign o_flags.den_zero = (r_dmag == '0);
    assign o_flags.num_zero = (r_nmag == '0);
    assign o_flags.u_even   = !r_u[0];
    assign o_flags.v_even   = !r_v[0];
    assign o_flags.u_eq_v   = (r_u == r_v);
    assign o_flags.cnt_done = (r_cnt == CW'(WIDTH));

endmodule

// ----- rtl/fraction_lowest_terms.sv -----
// Reduces a signed fraction to lowest terms.
// Input stream: s_axis_tdata carries the numerator in the low WIDTH bits and
// the denominator above it; a request is taken when tvalid and tready are
// both high. Output stream: m_axis_tdata carries the reduced numerator and
// denominator in the same layout, m_axis_tuser the status flag (set when the
// denominator is zero, in which case the inputs come back unchanged).
// A zero numerator with a nonzero denominator gives 0/1. Both values keep
// their own sign.
// One request is worked on at a time. A zero denominator is caught by the
// first check step after the load and a zero numerator by the second.
// Otherwise the microcoded sequencer runs a binary gcd of halvings,
// subtractions and parity tests, whose length depends on the operands,
// then two restoring divisions by the gcd, numerator first. The divider
// produces one quotient bit per cycle. The result sits in an output
// register, so the next request is taken at the edge at which it appears;
// if the receiver stalls, the sequencer holds at its final step until the
// register is free. Reset returns the sequencer to idle and drops
// m_axis_tvalid; no clearing pass is needed.
module fraction_lowest_terms import flt_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [((2*WIDTH+7)/8)*8-1:0]      s_axis_tdata,   // num_in, den_in
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [((2*WIDTH+7)/8)*8-1:0]      m_axis_tdata,   // num_out, den_out
    output logic                              m_axis_tuser    // status
);

    localparam int TDATA_W = ((2 * WIDTH + 7) / 8) * 8;

    t_op              w_op;
    t_dp_flags        w_flags;
    logic             w_emit;
    logic             w_out_busy;
    logic [WIDTH-1:0] w_num, w_den;
    logic             w_status;

    logic             r_m_valid;
    logic [WIDTH-1:0] r_m_num, r_m_den;
    logic             r_m_status;

    assign w_out_busy = r_m_valid && !m_axis_tready;

    flt_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_busy (w_out_busy),
        .i_flags    (w_flags),
        .o_in_ready (s_axis_tready),
        .o_op       (w_op)
    );

    flt_datapath #(.WIDTH(WIDTH)) u_datapath (
        .i_clk    (i_clk),
        .i_op     (w_op),
        .i_num    (s_axis_tdata[WIDTH-1:0]),
        .i_den    (s_axis_tdata[2*WIDTH-1:WIDTH]),
        .o_flags  (w_flags),
        .o_emit   (w_emit),
        .o_num    (w_num),
        .o_den    (w_den),
        .o_status (w_status)
    );

    // The datapath writes its result registers on the emit step, so they are
    // copied in the following cycle.
    logic r_emit_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_d  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_emit_d <= w_emit;
            if (r_emit_d) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_emit_d) begin
            r_m_num    <= w_num;
            r_m_den    <= w_den;
            r_m_status <= w_status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(TDATA_W - 2 * WIDTH){1'b0}}, r_m_den, r_m_num};
    assign m_axis_tuser  = r_m_status;

    // An error result always carries a zero denominator.
    a_err_den_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (r_m_den == '0))
        else $error("error result with nonzero denominator");

    // A good result never has a zero denominator.
    a_ok_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (r_m_den != '0))
        else $error("good result with zero denominator");

    // A zero numerator reduces to a denominator of one.
    a_zero_num_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser && (r_m_num == '0)) |->
        (r_m_den == WIDTH'(1)))
        else $error("zero numerator not reduced to 0/1");

    // The sequencer never emits in back-to-back cycles.
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> !w_emit)
        else $error("two results emitted back to back");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int W      = 32;
    localparam int TD_W   = 2 * W;
    localparam int IDLE_PCT = 18;
    localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [W-1:0] num;
        logic [W-1:0] den;
    } frac_t;

    typedef struct packed {
        logic [W-1:0] num;
        logic [W-1:0] den;
        logic         div_by_zero;
    } reduced_t;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [TD_W-1:0] s_axis_tdata = '0;     // num_in, den_in
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [TD_W-1:0] m_axis_tdata;          // num_out, den_out
    logic            m_axis_tuser;          // status

    frac_t    pending_fracs[$];
    reduced_t reduced_queue[$];
    frac_t    next_frac;
    reduced_t want;
    bit       steady = 1'b0;
    int       failures = 0;
    int       results_seen = 0;
    int       zero_den_seen = 0;
    int       zero_num_seen = 0;

    fraction_lowest_terms #(.WIDTH(W)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Euclid on the magnitudes, then each quotient takes back its own sign.
    function automatic reduced_t lowest_terms(input logic [W-1:0] n, input logic [W-1:0] d);
        logic [W-1:0] nmag, dmag, a, b, r, nq, dq;
        reduced_t res;
        nmag = n[W-1] ? -n : n;
        dmag = d[W-1] ? -d : d;
        if (dmag == '0) begin
            res = '{num: n, den: d, div_by_zero: 1'b1};
        end else if (nmag == '0) begin
            res = '{num: '0, den: 1, div_by_zero: 1'b0};
        end else begin
            a = nmag;
            b = dmag;
            while (b != '0) begin
                r = a % b;
                a = b;
                b = r;
            end
            nq = nmag / a;
            dq = dmag / a;
            res.num = n[W-1] ? -nq : nq;
            res.den = d[W-1] ? -dq : dq;
            res.div_by_zero = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [W-1:0] signed_as(input logic [W-1:0] mag, input bit neg);
        return neg ? -mag : mag;
    endfunction

    // Any word in the stated range; the most negative value is left out.
    function automatic logic [W-1:0] any_word();
        logic [W-1:0] v;
        v = $urandom;
        while (v == MOST_NEG)
            v = $urandom;
        return v;
    endfunction

    function automatic frac_t random_frac();
        logic [W-1:0] g, a, b, lim;
        frac_t f;
        int kind;
        kind = $urandom_range(9);
        case (kind)
            0: begin
                f.num = any_word();
                f.den = any_word();
            end
            1: begin
                f.num = ($urandom_range(3) == 0) ? '0 : any_word();
                f.den = '0;
            end
            2: begin
                f.num = '0;
                f.den = any_word();
                if (f.den == '0)
                    f.den = 1;
            end
            3: begin
                // Factors of two on both sides drive the halving steps.
                a = ($urandom | 1) >> $urandom_range(W - 1, 1);
                b = ($urandom | 1) >> $urandom_range(W - 1, 1);
                f.num = signed_as(a << $urandom_range(W - 1 - $clog2(a + 1)), $urandom_range(1));
                f.den = signed_as(b << $urandom_range(W - 1 - $clog2(b + 1)), $urandom_range(1));
            end
            4: begin
                f.num = signed_as($urandom_range(100), $urandom_range(1));
                f.den = signed_as($urandom_range(100), $urandom_range(1));
            end
            default: begin
                // A shared factor of random size, so the gcd is rarely one.
                g = $urandom >> $urandom_range(W - 1, 1);
                if (g == '0)
                    g = 1;
                lim = MAX_POS / g;
                a = $urandom_range(lim, 1);
                b = $urandom_range(lim, 1);
                f.num = signed_as(a * g, $urandom_range(1));
                f.den = signed_as(b * g, $urandom_range(1));
            end
        endcase
        return f;
    endfunction

    // Sender: once a request has gone the next follows, with random gaps unless steady.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                reduced_queue.push_back(lowest_terms(s_axis_tdata[W-1:0], s_axis_tdata[TD_W-1:W]));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_fracs.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    next_frac = pending_fracs.pop_front();
                    s_axis_tdata  <= {next_frac.den, next_frac.num};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure, and each result checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (m_axis_tuser)
                    zero_den_seen++;
                if (reduced_queue.size() == 0) begin
                    failures++;
                    $display("%0t: result with none outstanding: num %0d den %0d status %0b",
                             $time, $signed(m_axis_tdata[W-1:0]),
                             $signed(m_axis_tdata[TD_W-1:W]), m_axis_tuser);
                end else begin
                    want = reduced_queue.pop_front();
                    if (want.num != m_axis_tdata[W-1:0]) begin
                        failures++;
                        $display("%0t: num_out mismatch, expected %0d, actual %0d", $time,
                                 $signed(want.num), $signed(m_axis_tdata[W-1:0]));
                    end
                    if (want.den != m_axis_tdata[TD_W-1:W]) begin
                        failures++;
                        $display("%0t: den_out mismatch, expected %0d, actual %0d", $time,
                                 $signed(want.den), $signed(m_axis_tdata[TD_W-1:W]));
                    end
                    if (want.div_by_zero != m_axis_tuser) begin
                        failures++;
                        $display("%0t: status mismatch, expected %0b, actual %0b", $time,
                                 want.div_by_zero, m_axis_tuser);
                    end
                    if (!want.div_by_zero && want.num == '0)
                        zero_num_seen++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_fracs.size() != 0 || s_axis_tvalid || reduced_queue.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            pending_fracs.push_back(random_frac());
    endtask

    task automatic queue_frac(input logic [W-1:0] n, input logic [W-1:0] d);
        pending_fracs.push_back('{num: n, den: d});
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed cases: zero denominator, zero numerator, the extremes and all sign pairs.
        queue_frac('0, '0);
        queue_frac(7, '0);
        queue_frac(-MAX_POS, '0);
        queue_frac('0, 5);
        queue_frac('0, -5);
        queue_frac('0, MAX_POS);
        queue_frac(1, 1);
        queue_frac(MAX_POS, MAX_POS);
        queue_frac(MAX_POS, -MAX_POS);
        queue_frac(-MAX_POS, 1);
        queue_frac(1, -MAX_POS);
        queue_frac(6, 4);
        queue_frac(-6, 4);
        queue_frac(6, -4);
        queue_frac(-6, -4);
        queue_frac(32'd1 << 30, 32'd1 << 20);
        queue_frac(MAX_POS, 2);
        queue_frac(-(32'd1 << 30), 3);
        queue_frac(3 * 46337, -(5 * 46337));
        queue_frac(2147483629, 2147483587);
        queue_frac(32'h5555_5555, 32'h2AAA_AAAA);
        queue_frac(-32'd1000000, 32'd1024);

        // Queue no random cases until every directed result is in.
        wait_drained();

        queue_random(400);
        wait_drained();

        steady = 1'b1;
        queue_random(300);
        wait_drained();

        steady = 1'b0;
        queue_random(500);
        wait_drained();

        repeat (300) @(posedge i_clk);
        $display("Reduced %0d fractions: %0d with a zero denominator, %0d with a zero numerator,",
                 results_seen, zero_den_seen, zero_num_seen);
        $display("under random stalls on both sides and one long run with none.");
        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timed out with %0d results still outstanding.", reduced_queue.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
